### hw/rtl/vfcm_pkg.sv
// Shared types, constants and lookup tables for the voxel face mesher.
package vfcm_pkg;

    localparam int InDataW  = 120;
    localparam int OutDataW = 144;
    localparam int FaceW    = 3;
    localparam int NumFaces = 6;

    localparam logic [3:0] KIND_AIR   = 4'd0;
    localparam logic [3:0] KIND_GRASS = 4'd1;
    localparam logic [3:0] KIND_DIRT  = 4'd2;
    localparam logic [3:0] KIND_STONE = 4'd3;
    localparam logic [3:0] KIND_WOOD  = 4'd4;
    localparam logic [3:0] KIND_LEAF  = 4'd5;
    localparam logic [3:0] KIND_SAND  = 4'd6;
    localparam logic [3:0] KIND_SNOW  = 4'd7;
    localparam logic [3:0] KIND_BEDRK = 4'd8;
    localparam logic [3:0] KIND_WATER = 4'd9;

    localparam logic [2:0] FACE_YP = 3'd0;
    localparam logic [2:0] FACE_YN = 3'd1;
    localparam logic [2:0] FACE_XP = 3'd2;
    localparam logic [2:0] FACE_XN = 3'd3;
    localparam logic [2:0] FACE_ZP = 3'd4;
    localparam logic [2:0] FACE_ZN = 3'd5;

    localparam logic [2:0] LAST_VTX = 3'd5;

    // UV corner codes
    localparam logic [1:0] UV_BL = 2'd0;
    localparam logic [1:0] UV_BR = 2'd1;
    localparam logic [1:0] UV_TR = 2'd2;
    localparam logic [1:0] UV_TL = 2'd3;

    // Input word, block_kind in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic [23:0]        neighbor_levels;
        logic [23:0]        neighbor_kinds;
        logic signed [23:0] cell_z;
        logic signed [12:0] cell_y;
        logic signed [23:0] cell_x;
        logic [3:0]         water_level;
        logic [3:0]         block_kind;
    } in_word_t;

    // Output word, pos_x in the lowest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [8:0]         tex_v;
        logic [8:0]         tex_u;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } out_word_t;

    // Per-cell values held while its faces are emitted
    typedef struct packed {
        logic [3:0]         kind;
        logic [31:0]        base_x;
        logic [31:0]        base_y;
        logic [31:0]        base_z;
        logic signed [8:0]  top_off;
    } cell_t;

    // Corner sign bits {z, y, x}: 1 is the +half side
    localparam logic [2:0] CORNER_SIGN [8] = '{
        3'b000, 3'b001, 3'b011, 3'b010,
        3'b100, 3'b101, 3'b111, 3'b110
    };

    localparam logic [2:0] FACE_CORNER [6][6] = '{
        '{3'd2, 3'd3, 3'd7, 3'd7, 3'd6, 3'd2},
        '{3'd0, 3'd1, 3'd5, 3'd5, 3'd4, 3'd0},
        '{3'd1, 3'd2, 3'd6, 3'd6, 3'd5, 3'd1},
        '{3'd0, 3'd4, 3'd7, 3'd7, 3'd3, 3'd0},
        '{3'd4, 3'd5, 3'd6, 3'd6, 3'd7, 3'd4},
        '{3'd0, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0}
    };

    localparam logic [1:0] FACE_UV [6][6] = '{
        '{UV_BR, UV_BL, UV_TL, UV_TL, UV_TR, UV_BR},
        '{UV_BL, UV_BR, UV_TR, UV_TR, UV_TL, UV_BL},
        '{UV_BL, UV_TL, UV_TR, UV_TR, UV_BR, UV_BL},
        '{UV_BR, UV_BL, UV_TL, UV_TL, UV_TR, UV_BR},
        '{UV_BR, UV_BL, UV_TL, UV_TL, UV_TR, UV_BR},
        '{UV_BL, UV_TL, UV_TR, UV_TR, UV_BR, UV_BL}
    };

    // {red, green, blue} per kind
    localparam logic [23:0] KIND_RGB [16] = '{
        24'hFFFFFF, 24'hFFFFFF, 24'hCC9966, 24'h999999,
        24'hA1522E, 24'hFFFFFF, 24'hEDD6B0, 24'hF2F2FA,
        24'h808080, 24'h4D80CC, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
    };

    // Atlas row edges in Q.8: round(row * 256 / 3)
    localparam logic [8:0] ROW_V [4] = '{9'd0, 9'd85, 9'd171, 9'd256};

    // Atlas tile index for a kind and face
    function automatic logic [3:0] tex_of(input logic [3:0] kind, input logic [2:0] face);
        logic [3:0] t;
        begin
            case (kind)
                KIND_GRASS: t = (face == FACE_YP) ? 4'd0 : ((face == FACE_YN) ? 4'd2 : 4'd1);
                KIND_DIRT:  t = 4'd2;
                KIND_STONE: t = 4'd3;
                KIND_WOOD:  t = (face <= FACE_YN) ? 4'd5 : 4'd4;
                KIND_LEAF:  t = 4'd6;
                KIND_SAND:  t = 4'd7;
                KIND_SNOW:  t = 4'd8;
                KIND_BEDRK: t = 4'd9;
                KIND_WATER: t = 4'd10;
                default:    t = 4'd3;
            endcase
            return t;
        end
    endfunction

    // Offset of the upper face from the cell center in Q.8:
    // round(256*(8-level)/9) - 128 for flowing water, else +128
    function automatic logic signed [8:0] top_off_of(input logic water,
                                                     input logic [3:0] level);
        logic signed [8:0] o;
        begin
            o = 9'sd128;
            if (water)
            begin
                case (level)
                    4'd1:    o = 9'sd71;
                    4'd2:    o = 9'sd43;
                    4'd3:    o = 9'sd14;
                    4'd4:    o = -9'sd14;
                    4'd5:    o = -9'sd43;
                    4'd6:    o = -9'sd71;
                    4'd7:    o = -9'sd100;
                    default: o = 9'sd128;
                endcase
            end
            return o;
        end
    endfunction

endpackage

### hw/rtl/vfcm_vertex_gen.sv
// Vertex builder: position, atlas UV and color of one face corner.
module vfcm_vertex_gen (
    input  vfcm_pkg::cell_t     cur_cell,
    input  logic [2:0]          face,
    input  logic [2:0]          vtx,
    output vfcm_pkg::out_word_t vert
);
    import vfcm_pkg::*;

    logic [2:0]  corner;
    logic [2:0]  sgn;
    logic [3:0]  tex;
    logic [1:0]  col;
    logic [1:0]  row;
    logic [8:0]  u0;
    logic [8:0]  u1;
    logic [8:0]  v0;
    logic [8:0]  v1;
    logic [31:0] top_ext;
    logic [23:0] rgb;

    always_comb
    begin
        corner  = FACE_CORNER[face][vtx];
        sgn     = CORNER_SIGN[corner];
        top_ext = {{23{cur_cell.top_off[8]}}, cur_cell.top_off};
        tex     = tex_of(cur_cell.kind, face);
        col     = tex[1:0];
        row     = (tex[3:2] > 2'd2) ? 2'd2 : tex[3:2];
        u0      = {1'b0, col, 6'b0};
        u1      = u0 + 9'd64;
        v0      = ROW_V[row];
        v1      = ROW_V[2'(row + 2'd1)];
        rgb     = KIND_RGB[cur_cell.kind];

        vert       = '0;
        vert.pos_x = sgn[0] ? cur_cell.base_x + 32'd128 : cur_cell.base_x - 32'd128;
        vert.pos_y = sgn[1] ? cur_cell.base_y + top_ext  : cur_cell.base_y - 32'd128;
        vert.pos_z = sgn[2] ? cur_cell.base_z + 32'd128 : cur_cell.base_z - 32'd128;
        vert.red   = rgb[23:16];
        vert.green = rgb[15:8];
        vert.blue  = rgb[7:0];

        case (FACE_UV[face][vtx])
            UV_BL:
            begin
                vert.tex_u = u0;
                vert.tex_v = v1;
            end
            UV_BR:
            begin
                vert.tex_u = u1;
                vert.tex_v = v1;
            end
            UV_TR:
            begin
                vert.tex_u = u1;
                vert.tex_v = v0;
            end
            default:
            begin
                vert.tex_u = u0;
                vert.tex_v = v0;
            end
        endcase
    end

endmodule

### hw/rtl/voxel_face_cull_mesher_core.sv
// Top level of the voxel face mesher: face culling and vertex emission.
//
//  Channel | Dir | Word contents (lowest bits first)
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | tdata: block_kind, water_level, cell_x, cell_y, cell_z,
//          |     |        neighbor_kinds, neighbor_levels (117 bits, pad 120)
//  m_*     | out | tdata: pos_x, pos_y, pos_z, tex_u, tex_v, red, green, blue
//          |     |        (138 bits, pad 144); tuser: face code; tlast: last_vertex
//
// A cell word lands in the cell register; visible faces are then walked one
// vertex per cycle, while m_tready does not stall, into the output register,
// six vertices per exposed face, and an air or fully culled cell emits none.
// The next cell is taken in the same cycle that the current cell's last
// vertex moves to the output register, so cells follow back to back.
// The output register advances whenever it is empty or m_tready is high; a
// stall on m_tready holds the vertex and stops the walk.
// rst_n clears both valid flags; payload registers are not reset.
module voxel_face_cull_mesher_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // block_kind, water_level, cell_x, cell_y, cell_z, neighbor_kinds,
    // neighbor_levels, zero pad
    input  logic [vfcm_pkg::InDataW-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, red, green, blue, zero pad
    output logic [vfcm_pkg::OutDataW-1:0] m_tdata,
    // face code
    output logic [vfcm_pkg::FaceW-1:0]    m_tuser,
    output logic                          m_tlast
);
    import vfcm_pkg::*;

    in_word_t   in_word;
    logic [5:0] mask_in;
    logic       in_water;
    cell_t      cell_in;

    cell_t      cell_reg;
    logic       cell_vld_reg;
    logic       cell_vld_next;
    logic [5:0] mask_reg;
    logic [5:0] mask_next;
    logic [2:0] vtx_reg;
    logic [2:0] vtx_next;

    logic       m_vld_reg;
    logic       m_vld_next;
    out_word_t  m_data_reg;
    logic [2:0] m_face_reg;
    logic       m_last_reg;

    logic [2:0] face;
    logic [5:0] mask_rest;
    out_word_t  vert;
    logic       out_free;
    logic       emit;
    logic       last;
    logic       cell_done;
    logic       accept;

    // Decode the incoming cell and its visible faces
    always_comb
    begin
        in_word  = in_word_t'(s_tdata);
        in_water = (in_word.block_kind == KIND_WATER);
        for (int f = 0; f < NumFaces; f++)
        begin
            logic [3:0] nk;
            logic [3:0] nl;
            nk = in_word.neighbor_kinds[4*f +: 4];
            nl = in_word.neighbor_levels[4*f +: 4];
            // Air neighbor always shows the face; water shows it unless
            // this is water at the same level
            mask_in[f] = (in_word.block_kind != KIND_AIR) &&
                         ((nk == KIND_AIR) ||
                          ((nk == KIND_WATER) &&
                           !(in_water && (nl == in_word.water_level))));
        end
        cell_in.kind    = in_word.block_kind;
        cell_in.base_x  = {in_word.cell_x, 8'b0};
        cell_in.base_y  = {{11{in_word.cell_y[12]}}, in_word.cell_y, 8'b0};
        cell_in.base_z  = {in_word.cell_z, 8'b0};
        cell_in.top_off = top_off_of(in_water, in_word.water_level);
    end

    // Pick the lowest face still pending
    always_comb
    begin
        face = FACE_ZN;
        for (int f = NumFaces - 1; f >= 0; f--)
        begin
            if (mask_reg[f])
            begin
                face = 3'(f);
            end
        end
        mask_rest = mask_reg & ~(6'b1 << face);
    end

    vfcm_vertex_gen u_vertex_gen (
        .cur_cell (cell_reg),
        .face     (face),
        .vtx      (vtx_reg),
        .vert     (vert)
    );

    // Handshake and walk control
    assign out_free  = !m_vld_reg || m_tready;
    assign emit      = cell_vld_reg && (mask_reg != 6'b0) && out_free;
    assign last      = (vtx_reg == LAST_VTX) && (mask_rest == 6'b0);
    assign cell_done = cell_vld_reg && ((mask_reg == 6'b0) || (emit && last));
    assign s_tready  = !cell_vld_reg || cell_done;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        cell_vld_next = cell_vld_reg;
        mask_next     = mask_reg;
        vtx_next      = vtx_reg;
        if (accept)
        begin
            cell_vld_next = 1'b1;
            mask_next     = mask_in;
            vtx_next      = 3'd0;
        end
        else if (cell_done)
        begin
            cell_vld_next = 1'b0;
            mask_next     = 6'b0;
        end
        else if (emit)
        begin
            if (vtx_reg == LAST_VTX)
            begin
                // face finished: drop it and restart the corner count
                mask_next = mask_rest;
                vtx_next  = 3'd0;
            end
            else
            begin
                vtx_next = vtx_reg + 3'd1;
            end
        end

        m_vld_next = m_vld_reg;
        if (emit)
        begin
            m_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= 1'b0;
            mask_reg     <= 6'b0;
            vtx_reg      <= 3'd0;
            m_vld_reg    <= 1'b0;
        end
        else
        begin
            cell_vld_reg <= cell_vld_next;
            mask_reg     <= mask_next;
            vtx_reg      <= vtx_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    // Payload registers: load the cell on accept, the vertex on emit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_reg <= cell_in;
        end
        if (emit)
        begin
            m_data_reg <= vert;
            m_face_reg <= face;
            m_last_reg <= last;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_face_reg;
    assign m_tlast  = m_last_reg;

endmodule

### hw/rtl/vfcm_checker.sv
// Port-level checker for the voxel face mesher, bound to the top level.
module vfcm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vfcm_pkg::OutDataW-1:0] m_tdata,
    input logic [vfcm_pkg::FaceW-1:0]    m_tuser,
    input logic                          m_tlast
);
    import vfcm_pkg::*;

    // Hold a stalled vertex
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled vertex word changed");

    a_face: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 3'd6) && (m_tuser != 3'd7))
        else $error("face code out of range");

    // Atlas u lands on a column edge
    a_tex_u: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[101:96] == 6'd0) && (m_tdata[104:96] <= 9'd256))
        else $error("tex_u off a column edge");

    // Atlas v lands on a row edge
    a_tex_v: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[113:105] == ROW_V[0]) || (m_tdata[113:105] == ROW_V[1]) ||
                     (m_tdata[113:105] == ROW_V[2]) || (m_tdata[113:105] == ROW_V[3]))
        else $error("tex_v off a row edge");

endmodule

bind voxel_face_cull_mesher_core vfcm_checker u_vfcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/voxel_face_cull_mesher_core_tb.sv
// Self-checking testbench for the voxel face mesher: culling, vertex order and payload.
`timescale 1ns / 1ps

module voxel_face_cull_mesher_core_tb;

    import vfcm_pkg::*;

    // Kinds past water have no name in the package: plain solid, stone tile
    localparam logic [3:0] KIND_PLAIN_FIRST = 4'd10;
    localparam logic [3:0] KIND_PLAIN_LAST  = 4'd15;

    localparam int DirectedWaterCells = 10;
    localparam int RandomCells        = 245;
    localparam int DrainCycles        = 64;

    // One expected output word with its sideband
    typedef struct packed {
        out_word_t  word;
        logic [2:0] face;
        logic       last;
    } vertex_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_CHOKE,
        SINK_BEAT
    } sink_mode_t;

    // Predicts the vertices of each accepted cell and checks them in order.
    class vertex_ledger;
        vertex_t pending[$];
        int      faults;

        function new();
            faults = 0;
        endfunction

        // Expand one cell into the vertices of its exposed faces.
        function void add_cell(in_word_t c);
            vertex_t     cell_verts[$];
            vertex_t     vx;
            logic        water;
            logic [31:0] bx, by, bz, top;
            logic [3:0]  nkind, nlev, tile;
            logic [1:0]  col;
            logic [8:0]  u0, u1, v0, v1;
            logic [17:0] corner_seq;
            logic [11:0] uv_seq;
            logic [2:0]  corner, fc;
            logic [23:0] rgb;
            int          top_q8;
            begin
                if (c.block_kind == KIND_AIR)
                    return;
                water = (c.block_kind == KIND_WATER);
                bx = {c.cell_x, 8'h00};
                by = {{11{c.cell_y[12]}}, c.cell_y, 8'h00};
                bz = {c.cell_z, 8'h00};
                // Flowing water lowers the upper corners to (8 - level) / 9
                top_q8 = 128;
                if (water && c.water_level >= 4'd1 && c.water_level <= 4'd7)
                    top_q8 = ((8 - int'(c.water_level)) * 512 + 9) / 18 - 128;
                top = top_q8;
                case (c.block_kind)
                    KIND_DIRT:  rgb = 24'hCC9966;
                    KIND_STONE: rgb = 24'h999999;
                    KIND_WOOD:  rgb = 24'hA1522E;
                    KIND_SAND:  rgb = 24'hEDD6B0;
                    KIND_SNOW:  rgb = 24'hF2F2FA;
                    KIND_BEDRK: rgb = 24'h808080;
                    KIND_WATER: rgb = 24'h4D80CC;
                    default:    rgb = 24'hFFFFFF;
                endcase
                for (int f = 0; f < NumFaces; f++)
                begin
                    fc    = f[2:0];
                    nkind = c.neighbor_kinds[4*f +: 4];
                    nlev  = c.neighbor_levels[4*f +: 4];
                    // Any neighbor other than air or water hides the face
                    if (nkind != KIND_AIR && nkind != KIND_WATER)
                        continue;
                    // Water against water at the same level shows no face
                    if (nkind == KIND_WATER && water && nlev == c.water_level)
                        continue;
                    case (c.block_kind)
                        KIND_GRASS: tile = (fc == FACE_YP) ? 4'd0 :
                                           ((fc == FACE_YN) ? 4'd2 : 4'd1);
                        KIND_DIRT:  tile = 4'd2;
                        KIND_WOOD:  tile = (fc == FACE_YP || fc == FACE_YN) ? 4'd5 : 4'd4;
                        KIND_LEAF:  tile = 4'd6;
                        KIND_SAND:  tile = 4'd7;
                        KIND_SNOW:  tile = 4'd8;
                        KIND_BEDRK: tile = 4'd9;
                        KIND_WATER: tile = 4'd10;
                        default:    tile = 4'd3;
                    endcase
                    // Atlas is 4 columns by 3 rows
                    col = tile[1:0];
                    u0  = 9'(col) * 9'd64;
                    u1  = u0 + 9'd64;
                    case (tile[3:2])
                        2'd0:    begin v0 = 9'd0;   v1 = 9'd85;  end
                        2'd1:    begin v0 = 9'd85;  v1 = 9'd171; end
                        default: begin v0 = 9'd171; v1 = 9'd256; end
                    endcase
                    // Corner and UV order per face, first vertex in the top digits
                    case (fc)
                        FACE_YP: corner_seq = 18'o237762;
                        FACE_YN: corner_seq = 18'o015540;
                        FACE_XP: corner_seq = 18'o126651;
                        FACE_XN: corner_seq = 18'o047730;
                        FACE_ZP: corner_seq = 18'o456674;
                        default: corner_seq = 18'o032210;
                    endcase
                    case (fc)
                        FACE_YN:          uv_seq = {UV_BL, UV_BR, UV_TR, UV_TR, UV_TL, UV_BL};
                        FACE_XP, FACE_ZN: uv_seq = {UV_BL, UV_TL, UV_TR, UV_TR, UV_BR, UV_BL};
                        default:          uv_seq = {UV_BR, UV_BL, UV_TL, UV_TL, UV_TR, UV_BR};
                    endcase
                    for (int v = 0; v < 6; v++)
                    begin
                        corner = corner_seq[17-3*v -: 3];
                        // Corners 1, 2, 5, 6 sit on +x; bit 1 is +y, bit 2 is +z
                        vx.word.pos_x = (corner[0] ^ corner[1]) ? bx + 32'd128 : bx - 32'd128;
                        vx.word.pos_y = corner[1] ? by + top : by - 32'd128;
                        vx.word.pos_z = corner[2] ? bz + 32'd128 : bz - 32'd128;
                        case (uv_seq[11-2*v -: 2])
                            UV_BL:   begin vx.word.tex_u = u0; vx.word.tex_v = v1; end
                            UV_BR:   begin vx.word.tex_u = u1; vx.word.tex_v = v1; end
                            UV_TR:   begin vx.word.tex_u = u1; vx.word.tex_v = v0; end
                            default: begin vx.word.tex_u = u0; vx.word.tex_v = v0; end
                        endcase
                        vx.word.red   = rgb[23:16];
                        vx.word.green = rgb[15:8];
                        vx.word.blue  = rgb[7:0];
                        vx.word.pad   = '0;
                        vx.face       = fc;
                        vx.last       = 1'b0;
                        cell_verts = {cell_verts, vx};
                    end
                end
                if (cell_verts.size() > 0)
                    cell_verts[cell_verts.size()-1].last = 1'b1;
                pending = {pending, cell_verts};
            end
        endfunction

        // Compare one output word with the oldest expected vertex.
        function void match_vertex(logic [OutDataW-1:0] data, logic [2:0] face, logic last);
            vertex_t   want;
            out_word_t got;
            string     wrong;
            begin
                got = data;
                if (pending.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: vertex with no cell pending: pos=(%0d,%0d,%0d) face %0d",
                                 $realtime, got.pos_x, got.pos_y, got.pos_z, face);
                    return;
                end
                want  = pending.pop_front();
                wrong = "";
                if (got.pos_x !== want.word.pos_x) wrong = {wrong, " pos_x"};
                if (got.pos_y !== want.word.pos_y) wrong = {wrong, " pos_y"};
                if (got.pos_z !== want.word.pos_z) wrong = {wrong, " pos_z"};
                if (got.tex_u !== want.word.tex_u) wrong = {wrong, " tex_u"};
                if (got.tex_v !== want.word.tex_v) wrong = {wrong, " tex_v"};
                if (got.red   !== want.word.red)   wrong = {wrong, " red"};
                if (got.green !== want.word.green) wrong = {wrong, " green"};
                if (got.blue  !== want.word.blue)  wrong = {wrong, " blue"};
                if (got.pad   !== want.word.pad)   wrong = {wrong, " pad"};
                if (face      !== want.face)       wrong = {wrong, " face"};
                if (last      !== want.last)       wrong = {wrong, " last_vertex"};
                if (wrong != "")
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $display("%0t: vertex mismatch in%s", $realtime, wrong);
                        $display("  expected pos=(%0d,%0d,%0d) uv=(%0d,%0d) rgb=(%0d,%0d,%0d) face %0d last %0d",
                                 want.word.pos_x, want.word.pos_y, want.word.pos_z,
                                 want.word.tex_u, want.word.tex_v, want.word.red,
                                 want.word.green, want.word.blue, want.face, want.last);
                        $display("  actual   pos=(%0d,%0d,%0d) uv=(%0d,%0d) rgb=(%0d,%0d,%0d) face %0d last %0d",
                                 got.pos_x, got.pos_y, got.pos_z, got.tex_u, got.tex_v,
                                 got.red, got.green, got.blue, face, last);
                    end
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    in_word_t            s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic [FaceW-1:0]    m_tuser;
    logic                m_tlast;

    vertex_ledger board;
    int           burst_left = 0;
    sink_mode_t   sink_mode  = SINK_OPEN;
    int           sink_left  = 0;
    int           sink_tick  = 0;

    voxel_face_cull_mesher_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop for a hung pipeline
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: switch among open, coin-flip, choked and rhythmic stall patterns
    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode <= sink_mode_t'(2'($urandom_range(0, 3)));
            sink_left <= $urandom_range(40, 300);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            SINK_OPEN:  m_tready <= 1'b1;
            SINK_COIN:  m_tready <= 1'($urandom_range(0, 1));
            SINK_CHOKE: m_tready <= ($urandom_range(0, 5) == 0);
            default:    m_tready <= ((sink_tick % 7) < 4);
        endcase
        sink_tick <= sink_tick + 1;
    end

    // Sample both handshakes on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.add_cell(s_tdata);
            if (m_tvalid && m_tready)
                board.match_vertex(m_tdata, m_tuser, m_tlast);
        end
    end

    function automatic in_word_t make_cell(logic [3:0] kind, logic [3:0] lvl,
                                           logic [23:0] x, logic [12:0] y, logic [23:0] z,
                                           logic [23:0] nk, logic [23:0] nl);
        in_word_t c;
        begin
            c                 = '0;
            c.block_kind      = kind;
            c.water_level     = lvl;
            c.cell_x          = x;
            c.cell_y          = y;
            c.cell_z          = z;
            c.neighbor_kinds  = nk;
            c.neighbor_levels = nl;
            return c;
        end
    endfunction

    // Mostly solid or water cells with air-heavy neighborhoods, some air cells
    function automatic in_word_t random_cell();
        in_word_t   c;
        int         pick;
        int         p;
        logic [3:0] nk;
        begin
            c    = '0;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                c.block_kind = KIND_AIR;
            else if (pick < 40)
                c.block_kind = KIND_WATER;
            else
                c.block_kind = 4'($urandom_range(1, 15));
            c.water_level = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(1, 7))
                                                        : 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:
                begin
                    c.cell_x = 24'($urandom_range(0, 127)) - 24'd64;
                    c.cell_y = 13'($urandom_range(0, 127)) - 13'd64;
                    c.cell_z = 24'($urandom_range(0, 127)) - 24'd64;
                end
                1, 2:
                begin
                    c.cell_x = 24'($urandom);
                    c.cell_y = 13'($urandom);
                    c.cell_z = 24'($urandom);
                end
                default:
                begin
                    c.cell_x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                    c.cell_y = $urandom_range(0, 1) ? 13'h0FFF : 13'h1000;
                    c.cell_z = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                end
            endcase
            for (int f = 0; f < NumFaces; f++)
            begin
                p  = $urandom_range(0, 99);
                nk = (p < 45) ? KIND_AIR : ((p < 65) ? KIND_WATER : 4'($urandom_range(1, 15)));
                c.neighbor_kinds[4*f +: 4] = nk;
                // Water neighbors often match the level so that culling triggers
                c.neighbor_levels[4*f +: 4] = (nk == KIND_WATER && $urandom_range(0, 1) == 1)
                                              ? c.water_level : 4'($urandom_range(0, 15));
            end
            return c;
        end
    endfunction

    // Offer one cell, hold it until taken, then maybe drop valid for a gap.
    task automatic push_cell(input in_word_t c);
        int gap;
        begin
            s_tdata  <= c;
            s_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 11);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        logic [3:0] lvl;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Air gives nothing; then each kind with assorted partial culling
        push_cell(make_cell(KIND_AIR, 4'd0, 24'd5, 13'd5, 24'd5, 24'h000000, 24'h000000));
        push_cell(make_cell(KIND_GRASS, 4'd0, 24'd0, 13'd0, 24'd0, 24'h000000, 24'h000000));
        push_cell(make_cell(KIND_DIRT, 4'd15, 24'h7FFFFF, 13'h0FFF, 24'h7FFFFF,
                            24'h000000, 24'hFFFFFF));
        // Most negative corner: the low side of x and z wraps
        push_cell(make_cell(KIND_STONE, 4'd0, 24'h800000, 13'h1000, 24'h800000,
                            24'h000000, 24'h000000));
        push_cell(make_cell(KIND_WOOD, 4'd2, 24'd17, 13'h1FF0, 24'hFFFFF0, 24'h000900, 24'h000200));
        push_cell(make_cell(KIND_LEAF, 4'd9, 24'hFFFFFF, 13'd1, 24'd3, 24'h100000, 24'h000000));
        push_cell(make_cell(KIND_SAND, 4'd0, 24'd100, 13'd200, 24'd300, 24'h0000F0, 24'h000000));
        push_cell(make_cell(KIND_SNOW, 4'd7, 24'hFFFF00, 13'd40, 24'd9, 24'h0A0000, 24'h000000));
        push_cell(make_cell(KIND_BEDRK, 4'd0, 24'd1, 13'h1000, 24'd1, 24'h090909, 24'h000000));
        push_cell(make_cell(KIND_PLAIN_FIRST, 4'd0, 24'd2, 13'd2, 24'd2, 24'h000000, 24'h000000));
        push_cell(make_cell(KIND_PLAIN_FIRST + 4'd2, 4'd3, 24'd8, 13'd8, 24'd8,
                            24'h00C0D0, 24'h000000));
        push_cell(make_cell(KIND_PLAIN_LAST, 4'd0, 24'hFFFFF8, 13'h1FF8, 24'hFFFFF8,
                            24'h000000, 24'h000000));

        // Water at source, every flowing level, falling and the unused high levels
        for (int i = 0; i < DirectedWaterCells; i++)
        begin
            lvl = (i == DirectedWaterCells - 1) ? 4'd15 : 4'(i);
            push_cell(make_cell(KIND_WATER, lvl, 24'(i * 3 - 10), 13'(i - 4), 24'(7 - i),
                                24'h000000, 24'h000000));
        end

        // Water beside water: equal levels cull, others show
        push_cell(make_cell(KIND_WATER, 4'd3, 24'd0, 13'd0, 24'd0, 24'h999999, 24'h334343));
        // Fully enclosed by solids, including the plain kinds
        push_cell(make_cell(KIND_STONE, 4'd0, 24'd0, 13'd0, 24'd0, 24'hFEDCBA, 24'h000000));
        // Solid cell beside water at its own level stays fully visible
        push_cell(make_cell(KIND_STONE, 4'd5, 24'd4, 13'd4, 24'd4, 24'h999999, 24'h555555));

        for (int n = 0; n < RandomCells; n++)
            push_cell(random_cell());
        s_tvalid <= 1'b0;
        // Let the monitor log the final accepted cell before checking the queue
        @(posedge clk);

        while (board.pending.size() != 0)
            @(posedge clk);
        // Let any stray extra vertices show up
        repeat (DrainCycles) @(posedge clk);
        if (board.faults == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
